### src/msc_pkg.sv
// msc_pkg: shared widths, stage numbering, types and fixed-point helpers
// for the material shade combine pipeline. No dependencies.
package msc_pkg;

  // channel and field widths
  localparam int CHANNEL_BITS = 16;
  localparam int CH_W = CHANNEL_BITS;
  localparam int RGB_W = 48;
  localparam int DIR_W = 48;
  localparam int COMP_W = 16;
  localparam int WGT_W = 16;
  localparam int OP_W = 2;
  localparam int CH_SPAN = (3 * CH_W > RGB_W) ? 3 * CH_W : RGB_W;

  // q0.16 fractions that can also hold 1.0
  localparam int FRAC_W = 17;
  localparam int FRAC_SH = 16;
  localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;
  localparam int HALF_Q16 = 32768;
  localparam int MIX_W = CH_W + FRAC_W + 1;
  localparam int SCALE_W = CH_W + WGT_W + 1;
  localparam int RND_W = 2 * FRAC_W + 1;

  // dot product: q2.28 sum rounded to nearest q0.16
  localparam int DOT_W = 2 * COMP_W + 2;
  localparam int DOT_SH = 12;
  localparam int DOT_RND = 2048;

  // index of refraction divider
  localparam logic [WGT_W-1:0] IOR_ONE = 16'h1000;
  localparam int DEN_W = 17;
  localparam int DIVD_W = 32;
  localparam int Q_W = 17;

  // material kinds
  localparam logic [OP_W-1:0] OP_SOLID = 2'd0;
  localparam logic [OP_W-1:0] OP_PHONG = 2'd1;
  localparam logic [OP_W-1:0] OP_PBR = 2'd2;

  // pipeline stage numbering
  localparam int ST_PREP = 0;
  localparam int ST_MIX = 1;
  localparam int POW_STEPS = 4;
  localparam int ST_POW_LAST = ST_MIX + POW_STEPS;
  localparam int ST_DIV_LAST = ST_PREP + Q_W;
  localparam int ST_BASE = ST_DIV_LAST + 1;
  localparam int ST_FRES = ST_BASE + 1;
  localparam int ST_OUT = ST_FRES + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  typedef logic [CH_W-1:0] ch_t;
  typedef logic [2:0][CH_W-1:0] rgb3_t;
  typedef logic [FRAC_W-1:0] frac_t;
  typedef logic [WGT_W-1:0] wgt_t;
  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } stage_ctrl_t;

  // split a packed color into channels, r lowest
  function automatic rgb3_t unpack_rgb(input logic [RGB_W-1:0] rgb_in);
    logic [CH_SPAN-1:0] ext;
    rgb3_t res;
    ext = CH_SPAN'(rgb_in);
    for (int k = 0; k < 3; k++) begin
      res[k] = ext[k*CH_W +: CH_W];
    end
    return res;
  endfunction

  // pack channels back, dropping bits above the field
  function automatic logic [RGB_W-1:0] pack_rgb(input rgb3_t c);
    return RGB_W'(c);
  endfunction

  // signed q1.14 direction component k
  function automatic comp_t dir_comp(input logic [DIR_W-1:0] d, input int k);
    return comp_t'(d[k*COMP_W +: COMP_W]);
  endfunction

  // channel times q0.16 weight, rounded
  function automatic ch_t scale_q16(input ch_t c, input wgt_t w);
    logic [SCALE_W-1:0] acc;
    acc = SCALE_W'(c) * SCALE_W'(w) + SCALE_W'(HALF_Q16);
    return acc[CH_W+FRAC_SH-1:FRAC_SH];
  endfunction

  // a*(1-t) + b*t, rounded; never exceeds the larger input
  function automatic ch_t mix_q16(input ch_t a, input ch_t b, input frac_t t);
    logic [MIX_W-1:0] acc;
    acc = MIX_W'(a) * MIX_W'(ONE_Q16 - t) + MIX_W'(b) * MIX_W'(t)
          + MIX_W'(HALF_Q16);
    return acc[CH_W+FRAC_SH-1:FRAC_SH];
  endfunction

  // q0.16 product of two values up to 1.0, rounded
  function automatic frac_t mul_q16(input frac_t a, input frac_t b);
    logic [RND_W-1:0] acc;
    acc = RND_W'(a) * RND_W'(b) + RND_W'(HALF_Q16);
    return acc[FRAC_SH+FRAC_W-1:FRAC_SH];
  endfunction

  // clamp a phong sum to the channel maximum
  function automatic ch_t sat_ch(input logic [CH_W+1:0] v);
    return (|v[CH_W+1:CH_W]) ? {CH_W{1'b1}} : v[CH_W-1:0];
  endfunction

endpackage

### src/msc_in_if.sv
// msc_in_if: hit channel into the shading pipeline, valid/ready plus fields.
// Depends on msc_pkg for field widths.
interface msc_in_if;
  logic valid;
  logic ready;
  logic [msc_pkg::OP_W-1:0] op;
  logic [msc_pkg::DIR_W-1:0] view_dir;
  logic [msc_pkg::DIR_W-1:0] normal_dir;
  logic [msc_pkg::RGB_W-1:0] diffuse_rgb;
  logic [msc_pkg::RGB_W-1:0] reflected_rgb;
  logic [msc_pkg::RGB_W-1:0] refracted_rgb;
  logic [msc_pkg::WGT_W-1:0] reflect_weight;
  logic [msc_pkg::WGT_W-1:0] refract_weight;
  logic [msc_pkg::WGT_W-1:0] index_of_refraction;
  logic [msc_pkg::WGT_W-1:0] albedo_weight;
  logic [msc_pkg::WGT_W-1:0] opacity_weight;

  modport source (
    output valid, op, view_dir, normal_dir, diffuse_rgb, reflected_rgb,
           refracted_rgb, reflect_weight, refract_weight, index_of_refraction,
           albedo_weight, opacity_weight,
    input  ready
  );
  modport sink (
    input  valid, op, view_dir, normal_dir, diffuse_rgb, reflected_rgb,
           refracted_rgb, reflect_weight, refract_weight, index_of_refraction,
           albedo_weight, opacity_weight,
    output ready
  );
endinterface

### src/msc_out_if.sv
// msc_out_if: shaded color channel out of the pipeline, valid/ready plus color.
// Depends on msc_pkg for the color width.
interface msc_out_if;
  logic valid;
  logic ready;
  logic [msc_pkg::RGB_W-1:0] shaded_rgb;

  modport source (output valid, shaded_rgb, input ready);
  modport sink (input valid, shaded_rgb, output ready);
endinterface

### src/msc_pipe_ctrl.sv
// msc_pipe_ctrl: per-stage valid bits and load enables for the shading pipeline.
// A stage loads when it is empty or everything after it can move.
// Depends on msc_pkg.
module msc_pipe_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 out_ready,
  output logic                 in_ready,
  output logic                 out_valid,
  output msc_pkg::stage_ctrl_t ctrl
);

  logic [msc_pkg::NUM_STAGES-1:0] v_r;
  logic [msc_pkg::NUM_STAGES-1:0] v_nxt;
  logic [msc_pkg::NUM_STAGES-1:0] rdy;
  logic [msc_pkg::NUM_STAGES-1:0] upv;

  // a stage may load if it or any later stage holds a bubble or the output drains
  for (genvar i = 0; i < msc_pkg::NUM_STAGES; i++) begin : g_rdy
    assign rdy[i] = out_ready | ~(&v_r[msc_pkg::NUM_STAGES-1:i]);
  end

  // valid bits shift along with the data
  always_comb begin
    upv = {v_r[msc_pkg::NUM_STAGES-2:0], in_valid};
    v_nxt = (rdy & upv) | (~rdy & v_r);
    ctrl.en = rdy & upv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready = rdy[0];
  assign out_valid = v_r[msc_pkg::NUM_STAGES-1];

endmodule

### src/msc_ior_div.sv
// msc_ior_div: pipelined restoring divider for |ior-1|/(ior+1) in q0.16,
// rounded to nearest, one quotient bit per stage. Depends on msc_pkg.
module msc_ior_div (
  input  logic                         clk,
  input  msc_pkg::stage_ctrl_t         ctrl,
  input  msc_pkg::wgt_t                ior,
  output logic [msc_pkg::Q_W-1:0]      ratio
);

  logic [msc_pkg::DEN_W-1:0]  den_r [msc_pkg::ST_PREP:msc_pkg::ST_DIV_LAST-1];
  logic [msc_pkg::DIVD_W-1:0] dvd_r [msc_pkg::ST_PREP:msc_pkg::ST_DIV_LAST-1];
  logic [msc_pkg::DEN_W-1:0]  rem_r [msc_pkg::ST_MIX:msc_pkg::ST_DIV_LAST-1];
  logic [msc_pkg::Q_W-1:0]    quo_r [msc_pkg::ST_MIX:msc_pkg::ST_DIV_LAST];

  logic [msc_pkg::WGT_W-1:0]  num;
  logic [msc_pkg::DEN_W-1:0]  den;
  logic [msc_pkg::DIVD_W-1:0] dvd;

  // numerator, divisor and dividend with half the divisor added for rounding
  always_comb begin
    num = (ior >= msc_pkg::IOR_ONE) ? ior - msc_pkg::IOR_ONE : msc_pkg::IOR_ONE - ior;
    den = msc_pkg::DEN_W'(ior) + msc_pkg::DEN_W'(msc_pkg::IOR_ONE);
    dvd = {num, {msc_pkg::FRAC_SH{1'b0}}} + msc_pkg::DIVD_W'(den >> 1);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[msc_pkg::ST_PREP]) begin
      den_r[msc_pkg::ST_PREP] <= den;
      dvd_r[msc_pkg::ST_PREP] <= dvd;
    end
  end

  // one compare and subtract per stage, msb of the quotient first
  for (genvar s = msc_pkg::ST_MIX; s <= msc_pkg::ST_DIV_LAST; s++) begin : g_step
    localparam int J = msc_pkg::ST_DIV_LAST - s;
    logic [msc_pkg::DEN_W-1:0] rem_in;
    logic [msc_pkg::Q_W-1:0]   quo_in;
    logic [msc_pkg::DEN_W:0]   trial;
    logic [msc_pkg::DEN_W:0]   diff;
    logic                      fits;

    if (s == msc_pkg::ST_MIX) begin : g_first
      // the quotient fits in Q_W bits, so the top dividend bits are below den
      assign rem_in = msc_pkg::DEN_W'(dvd_r[s-1][msc_pkg::DIVD_W-1:msc_pkg::Q_W]);
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    always_comb begin
      trial = {rem_in, dvd_r[s-1][J]};
      diff = trial - {1'b0, den_r[s-1]};
      fits = (trial >= {1'b0, den_r[s-1]});
    end

    always_ff @(posedge clk) begin
      if (ctrl.en[s]) begin
        quo_r[s] <= {quo_in[msc_pkg::Q_W-2:0], fits};
      end
    end

    if (s < msc_pkg::ST_DIV_LAST) begin : g_carry
      always_ff @(posedge clk) begin
        if (ctrl.en[s]) begin
          rem_r[s] <= fits ? diff[msc_pkg::DEN_W-1:0] : trial[msc_pkg::DEN_W-1:0];
          den_r[s] <= den_r[s-1];
          dvd_r[s] <= dvd_r[s-1];
        end
      end
    end
  end

  assign ratio = quo_r[msc_pkg::ST_DIV_LAST];

endmodule

### src/msc_fresnel.sv
// msc_fresnel: schlick fresnel term per hit: dot product, (1-|v.n|)^5,
// base reflectance from the ior divider. Depends on msc_pkg, msc_ior_div.
module msc_fresnel (
  input  logic                        clk,
  input  msc_pkg::stage_ctrl_t        ctrl,
  input  logic [msc_pkg::DIR_W-1:0]   view_dir,
  input  logic [msc_pkg::DIR_W-1:0]   normal_dir,
  input  msc_pkg::wgt_t               ior,
  output msc_pkg::frac_t              fres
);

  logic signed [2*msc_pkg::COMP_W-1:0] prod_r [3];
  msc_pkg::frac_t x_r  [msc_pkg::ST_MIX:msc_pkg::ST_POW_LAST-1];
  msc_pkg::frac_t pw_r [msc_pkg::ST_MIX:msc_pkg::ST_BASE];
  msc_pkg::frac_t base_r;
  msc_pkg::frac_t fres_r;
  logic [msc_pkg::Q_W-1:0] ratio;

  logic signed [msc_pkg::DOT_W-1:0] dot;
  logic [msc_pkg::DOT_W-1:0] mag;
  logic [msc_pkg::DOT_W-1:0] cos_raw;
  msc_pkg::frac_t cosq;

  msc_ior_div u_div (
    .clk   (clk),
    .ctrl  (ctrl),
    .ior   (ior),
    .ratio (ratio)
  );

  // component products
  always_ff @(posedge clk) begin
    if (ctrl.en[msc_pkg::ST_PREP]) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= (2*msc_pkg::COMP_W)'(msc_pkg::dir_comp(view_dir, k))
                   * (2*msc_pkg::COMP_W)'(msc_pkg::dir_comp(normal_dir, k));
      end
    end
  end

  // |v.n| rounded to q0.16, clamped to 1.0
  always_comb begin
    dot = msc_pkg::DOT_W'(prod_r[0]) + msc_pkg::DOT_W'(prod_r[1])
        + msc_pkg::DOT_W'(prod_r[2]);
    mag = dot[msc_pkg::DOT_W-1] ? msc_pkg::DOT_W'(-dot) : msc_pkg::DOT_W'(dot);
    cos_raw = (mag + msc_pkg::DOT_W'(msc_pkg::DOT_RND)) >> msc_pkg::DOT_SH;
    cosq = (cos_raw > msc_pkg::DOT_W'(msc_pkg::ONE_Q16))
         ? msc_pkg::ONE_Q16 : cos_raw[msc_pkg::FRAC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[msc_pkg::ST_MIX]) begin
      x_r[msc_pkg::ST_MIX] <= msc_pkg::ONE_Q16 - cosq;
      pw_r[msc_pkg::ST_MIX] <= msc_pkg::ONE_Q16 - cosq;
    end
  end

  // x^5 by four rounded multiplies, then carried to the fresnel stage
  for (genvar s = msc_pkg::ST_MIX + 1; s <= msc_pkg::ST_BASE; s++) begin : g_pow
    if (s <= msc_pkg::ST_POW_LAST) begin : g_mul
      always_ff @(posedge clk) begin
        if (ctrl.en[s]) begin
          pw_r[s] <= msc_pkg::mul_q16(pw_r[s-1], x_r[s-1]);
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (ctrl.en[s]) begin
          pw_r[s] <= pw_r[s-1];
        end
      end
    end
    if (s < msc_pkg::ST_POW_LAST) begin : g_x
      always_ff @(posedge clk) begin
        if (ctrl.en[s]) begin
          x_r[s] <= x_r[s-1];
        end
      end
    end
  end

  // base reflectance r^2; r stays at or below 1.0 so no clamp is needed
  always_ff @(posedge clk) begin
    if (ctrl.en[msc_pkg::ST_BASE]) begin
      base_r <= msc_pkg::mul_q16(msc_pkg::FRAC_W'(ratio), msc_pkg::FRAC_W'(ratio));
    end
  end

  // f = b + (1-b)*x^5
  always_ff @(posedge clk) begin
    if (ctrl.en[msc_pkg::ST_FRES]) begin
      fres_r <= base_r + msc_pkg::mul_q16(msc_pkg::ONE_Q16 - base_r,
                                          pw_r[msc_pkg::ST_BASE]);
    end
  end

  assign fres = fres_r;

endmodule

### src/msc_color_path.sv
// msc_color_path: per-channel color scaling, phong sum, opacity mix and the
// final fresnel mix. Depends on msc_pkg; takes the fresnel term from msc_fresnel.
module msc_color_path (
  input  logic                        clk,
  input  msc_pkg::stage_ctrl_t        ctrl,
  input  logic [msc_pkg::OP_W-1:0]    op,
  input  logic [msc_pkg::RGB_W-1:0]   diffuse_rgb,
  input  logic [msc_pkg::RGB_W-1:0]   reflected_rgb,
  input  logic [msc_pkg::RGB_W-1:0]   refracted_rgb,
  input  msc_pkg::wgt_t               reflect_weight,
  input  msc_pkg::wgt_t               refract_weight,
  input  msc_pkg::wgt_t               albedo_weight,
  input  msc_pkg::wgt_t               opacity_weight,
  input  msc_pkg::frac_t              fres,
  output logic [msc_pkg::RGB_W-1:0]   shaded_rgb
);

  logic [msc_pkg::OP_W-1:0] op_r [msc_pkg::ST_PREP:msc_pkg::ST_FRES];
  msc_pkg::rgb3_t pa_r [msc_pkg::ST_MIX:msc_pkg::ST_FRES];
  msc_pkg::rgb3_t pb_r [msc_pkg::ST_MIX:msc_pkg::ST_FRES];
  msc_pkg::rgb3_t dif_r, rl_r, rs_r;
  msc_pkg::wgt_t  wop_r;
  msc_pkg::rgb3_t out_r;

  msc_pkg::rgb3_t dif_in, refl_in, refr_in;
  msc_pkg::wgt_t  rs_w;
  msc_pkg::rgb3_t pa_nxt;
  msc_pkg::rgb3_t out_nxt;

  // scale reflection and refraction; refraction weight depends on the material
  always_comb begin
    dif_in = msc_pkg::unpack_rgb(diffuse_rgb);
    refl_in = msc_pkg::unpack_rgb(reflected_rgb);
    refr_in = msc_pkg::unpack_rgb(refracted_rgb);
    rs_w = (op == msc_pkg::OP_PBR) ? albedo_weight : refract_weight;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[msc_pkg::ST_PREP]) begin
      op_r[msc_pkg::ST_PREP] <= op;
      dif_r <= dif_in;
      wop_r <= opacity_weight;
      for (int k = 0; k < 3; k++) begin
        rl_r[k] <= msc_pkg::scale_q16(refl_in[k], reflect_weight);
        rs_r[k] <= msc_pkg::scale_q16(refr_in[k], rs_w);
      end
    end
  end

  // phong sum or opacity mix; unknown kinds pass diffuse like solid color
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (op_r[msc_pkg::ST_PREP])
        msc_pkg::OP_PHONG: begin
          pa_nxt[k] = msc_pkg::sat_ch((msc_pkg::CH_W+2)'(dif_r[k])
                                      + (msc_pkg::CH_W+2)'(rl_r[k])
                                      + (msc_pkg::CH_W+2)'(rs_r[k]));
        end
        msc_pkg::OP_PBR: begin
          pa_nxt[k] = msc_pkg::mix_q16(rs_r[k], dif_r[k], msc_pkg::FRAC_W'(wop_r));
        end
        default: begin
          pa_nxt[k] = dif_r[k];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[msc_pkg::ST_MIX]) begin
      op_r[msc_pkg::ST_MIX] <= op_r[msc_pkg::ST_PREP];
      pa_r[msc_pkg::ST_MIX] <= pa_nxt;
      pb_r[msc_pkg::ST_MIX] <= rl_r;
    end
  end

  // hold partial colors while the fresnel term is computed
  for (genvar s = msc_pkg::ST_MIX + 1; s <= msc_pkg::ST_FRES; s++) begin : g_carry
    always_ff @(posedge clk) begin
      if (ctrl.en[s]) begin
        op_r[s] <= op_r[s-1];
        pa_r[s] <= pa_r[s-1];
        pb_r[s] <= pb_r[s-1];
      end
    end
  end

  // final fresnel mix; its result never exceeds the channel maximum
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (op_r[msc_pkg::ST_FRES] == msc_pkg::OP_PBR) begin
        out_nxt[k] = msc_pkg::mix_q16(pa_r[msc_pkg::ST_FRES][k],
                                      pb_r[msc_pkg::ST_FRES][k], fres);
      end else begin
        out_nxt[k] = pa_r[msc_pkg::ST_FRES][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[msc_pkg::ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign shaded_rgb = msc_pkg::pack_rgb(out_r);

endmodule

### src/material_shade_combine.sv
// material_shade_combine: top level of the hit shading pipeline.
// Depends on msc_pkg, msc_in_if, msc_out_if, msc_pipe_ctrl, msc_fresnel,
// msc_color_path.
//
// Takes one ray hit per cycle while the input is ready and returns one shaded
// color per hit, in order. The depth is set by the Schlick base reflectance:
// the division |ior-1|/(ior+1) runs as a 17-stage restoring divider, one
// quotient bit per stage, followed by the r^2 and Fresnel multiplies and the
// final color mix. Every stage has its own valid bit; a stalled output only
// holds the stages behind it that are full, so hits keep transferring in as
// long as the pipeline holds a bubble. Solid color and unknown kinds pass the
// diffuse color; phong channels saturate at the channel maximum and physically
// based mixes never exceed it.
module material_shade_combine (
  input  logic        clk,
  input  logic        rst_n,
  msc_in_if.sink      in_ch,
  msc_out_if.source   out_ch
);

  msc_pkg::stage_ctrl_t ctrl;
  msc_pkg::frac_t       fres;

  // stage valid bits and load enables
  msc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .ctrl      (ctrl)
  );

  // fresnel term, ready one stage before the output
  msc_fresnel u_fresnel (
    .clk        (clk),
    .ctrl       (ctrl),
    .view_dir   (in_ch.view_dir),
    .normal_dir (in_ch.normal_dir),
    .ior        (in_ch.index_of_refraction),
    .fres       (fres)
  );

  // color datapath and output register
  msc_color_path u_color (
    .clk            (clk),
    .ctrl           (ctrl),
    .op             (in_ch.op),
    .diffuse_rgb    (in_ch.diffuse_rgb),
    .reflected_rgb  (in_ch.reflected_rgb),
    .refracted_rgb  (in_ch.refracted_rgb),
    .reflect_weight (in_ch.reflect_weight),
    .refract_weight (in_ch.refract_weight),
    .albedo_weight  (in_ch.albedo_weight),
    .opacity_weight (in_ch.opacity_weight),
    .fres           (fres),
    .shaded_rgb     (out_ch.shaded_rgb)
  );

endmodule
